// File: rtl/core/fpfl_pkg.sv
// Shared types and constants for the fixed pool free list allocator.
// Holds command and status codes, controller states and the control/status structs.
// No dependencies.
package fpfl_pkg;

   localparam int IDX_W  = 8;
   localparam int LINK_W = 9;
   localparam int CNT_W  = 9;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;

   localparam logic [LINK_W-1:0] NULL_LINK  = 9'd256;
   localparam logic [CNT_W-1:0]  POOL_RESET = 9'd256;
   localparam logic [CNT_W-1:0]  POOL_MIN   = 9'd3;
   localparam logic [CNT_W-1:0]  POOL_MAX   = 9'd256;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_BAD_INDEX = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_READ,
      S_SWEEP,
      S_HOLD
   } fsm_state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic alloc_commit;
      logic free_commit;
      logic sweep_start;
      logic sweep_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic alloc_ok;
      logic free_ok;
      logic is_clear;
      logic sweep_last;
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/core/fpfl_datapath.sv
// Datapath of the free list allocator: link memory, head and count registers,
// re-chain sweep counter, configuration register and result output register.
// Depends on fpfl_pkg.
module fpfl_datapath #(
   parameter int MAX_SLOTS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fpfl_pkg::ctrl_cmd_type        cmd,
   output fpfl_pkg::dp_status_type       stat,
   input  logic [fpfl_pkg::CMD_W-1:0]    req_command,
   input  logic [fpfl_pkg::IDX_W-1:0]    req_free_index,
   input  logic                          csr_wr_en,
   input  logic [fpfl_pkg::CNT_W-1:0]    csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fpfl_pkg::STAT_W-1:0]   rsp_status,
   output logic [fpfl_pkg::IDX_W-1:0]    rsp_given_index,
   output logic [fpfl_pkg::CNT_W-1:0]    rsp_in_use_count
);
   import fpfl_pkg::*;

   localparam int DEPTH  = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [CNT_W-1:0]  DEPTH_N = CNT_W'(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [LINK_W-1:0] link_mem [DEPTH];

   logic [CNT_W-1:0]  pool_entries_ff;
   logic [CMD_W-1:0]  cmd_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        status_ff;
   logic [IDX_W-1:0]  given_ff;
   logic [ADDR_W-1:0] sweep_cnt_ff;
   logic [CNT_W-1:0]  sweep_n_ff;
   logic [LINK_W-1:0] rdata_ff;
   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]  rsp_given_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic [CNT_W-1:0]  n_sat, n_act;
   logic              head_null;
   status_type        status_calc;
   logic [LINK_W-1:0] sweep_nxt, sweep_val;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [LINK_W-1:0] wr_data;

   function automatic logic link_null(input logic [LINK_W-1:0] link);
      return link >= DEPTH_N;
   endfunction

   // active slot count: saturate to the legal range, then to the memory depth
   always_comb begin
      n_sat = pool_entries_ff;
      if (n_sat < POOL_MIN) begin
         n_sat = POOL_MIN;
      end else if (n_sat > POOL_MAX) begin
         n_sat = POOL_MAX;
      end
      n_act = (n_sat > DEPTH_N) ? DEPTH_N : n_sat;
   end

   always_comb begin
      head_null = link_null(head_ff);
      stat.alloc_ok = (cmd_ff == CMD_ALLOC) && (count_ff < n_act) && !head_null;
      stat.free_ok = (cmd_ff == CMD_FREE) && ({1'b0, idx_ff} < n_act);
      stat.is_clear = (cmd_ff == CMD_CLEAR);
      stat.sweep_last = (sweep_cnt_ff == LAST_ADDR);
      stat.out_free = !rsp_valid_ff || rsp_ready;
      if ((cmd_ff == CMD_ALLOC) && !stat.alloc_ok) begin
         status_calc = ST_EXHAUSTED;
      end else if ((cmd_ff == CMD_FREE) && !stat.free_ok) begin
         status_calc = ST_BAD_INDEX;
      end else begin
         status_calc = ST_OK;
      end
   end

   always_comb begin
      sweep_nxt = LINK_W'(sweep_cnt_ff) + LINK_W'(1);
      sweep_val = (sweep_nxt < sweep_n_ff) ? sweep_nxt : NULL_LINK;
      wr_en = cmd.sweep_step || cmd.free_commit;
      if (cmd.sweep_step) begin
         wr_addr = sweep_cnt_ff;
         wr_data = sweep_val;
      end else begin
         wr_addr = idx_ff[ADDR_W-1:0];
         wr_data = head_null ? NULL_LINK : head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= link_mem[head_ff[ADDR_W-1:0]];
   end

   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      if (cmd.alloc_commit) begin
         head_in = link_null(rdata_ff) ? NULL_LINK : rdata_ff;
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.free_commit) begin
         head_in = {1'b0, idx_ff};
         count_in = (count_ff == '0) ? '0 : count_ff - CNT_W'(1);
      end else if (cmd.sweep_step && stat.sweep_last) begin
         head_in = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_entries_ff <= POOL_RESET;
         head_ff <= '0;
         count_ff <= '0;
         sweep_cnt_ff <= '0;
         sweep_n_ff <= DEPTH_N;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pool_entries_ff <= csr_wr_data;
         end
         head_ff <= head_in;
         count_ff <= count_in;
         if (cmd.sweep_start) begin
            sweep_cnt_ff <= '0;
            sweep_n_ff <= n_act;
         end else if (cmd.sweep_step) begin
            sweep_cnt_ff <= sweep_cnt_ff + ADDR_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff <= req_command;
         idx_ff <= req_free_index;
      end
      if (cmd.exec) begin
         status_ff <= status_calc;
         given_ff <= '0;
      end else if (cmd.alloc_commit) begin
         given_ff <= head_ff[IDX_W-1:0];
      end
      if (cmd.out_load) begin
         rsp_status_ff <= status_ff;
         rsp_given_ff <= given_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_given_index = rsp_given_ff;
   assign rsp_in_use_count = rsp_count_ff;

endmodule

// File: rtl/core/fpfl_ctrl.sv
// Controller state machine of the free list allocator.
// Sequences request capture, execute, link read, re-chain sweep and result hand-off.
// Depends on fpfl_pkg.
module fpfl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  fpfl_pkg::dp_status_type  stat,
   output fpfl_pkg::ctrl_cmd_type   cmd
);
   import fpfl_pkg::*;

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.alloc_ok) begin
               state_in = S_READ;
            end else if (stat.is_clear) begin
               state_in = S_SWEEP;
            end else begin
               state_in = S_HOLD;
            end
         end
         S_READ: begin
            state_in = S_HOLD;
         end
         S_SWEEP: begin
            if (stat.sweep_last) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_step = 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load_req = req_valid;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            cmd.free_commit = stat.free_ok;
            cmd.sweep_start = stat.is_clear;
         end
         S_READ: begin
            cmd.alloc_commit = 1'b1;
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
         end
         S_HOLD: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: rtl/core/fixed_pool_free_list_top.sv
// Fixed pool free list allocator, top level.
// Request to result: allocate executes, reads the head link, then loads the result;
// free and others execute, then load the result; clear executes, re-chains the link
// memory, one link entry re-chained per cycle, then loads the result.
// Throughput: one command in flight; a waiting result stalls only the result load.
// Reset: synchronous; link memory re-chained over min(MAX_SLOTS,256) entries, req_ready low.
module fixed_pool_free_list_top #(
   parameter int MAX_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_free_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_given_index,
   output logic [8:0]  rsp_in_use_count,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);
   import fpfl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   fpfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fpfl_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_command      (req_command),
      .req_free_index   (req_free_index),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_given_index  (rsp_given_index),
      .rsp_in_use_count (rsp_in_use_count)
   );

endmodule

// File: rtl/core/fpfl_checker.sv
// Port-level checker for the free list allocator, bound to the top level.
// Depends on fpfl_pkg and fixed_pool_free_list_top.
module fpfl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_given_index,
   input logic [8:0] rsp_in_use_count
);
   import fpfl_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_given_index) && $stable(rsp_in_use_count))
      else $error("result changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("channel active right after reset");

   a_fail_no_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_given_index == '0)
      else $error("failed command returned a slot index");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_EXHAUSTED)
         || (rsp_status == ST_BAD_INDEX))
      else $error("undefined status code");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_in_use_count <= POOL_MAX)
      else $error("in-use count above pool size");

endmodule

bind fixed_pool_free_list_top fpfl_checker u_fpfl_checker (.*);
